/* src/atcrt_pkg.sv */
package atcrt_pkg;

  localparam int QueueDepth       = 8;
  localparam int QueueIdxW        = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QueueCntW        = $clog2(QueueDepth + 1);
  localparam int LineCapacity     = 512;
  localparam int LineCntW         = $clog2(LineCapacity);
  localparam int ResponseCapacity = 1024;
  localparam int RespCntW         = $clog2(ResponseCapacity);
  localparam int NumPat           = 10;
  localparam int MaxPatLen        = 11;
  localparam int FifoDepth        = 2;

  typedef enum logic [1:0] {
    REQ_BYTE   = 2'd0,
    REQ_SUBMIT = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    EV_ACCEPTED = 3'd0,
    EV_REJECTED = 3'd1,
    EV_START    = 3'd2,
    EV_DONE     = 3'd3,
    EV_URC      = 3'd4,
    EV_RESPONSE = 3'd5
  } event_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ERROR   = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_e;

  // Line classes produced by the front end.
  typedef enum logic [2:0] {
    CL_NONE  = 3'd0,
    CL_OK    = 3'd1,
    CL_ERROR = 3'd2,
    CL_URC   = 3'd3,
    CL_CEREG = 3'd4,
    CL_OTHER = 3'd5,
    CL_PDU   = 3'd6
  } line_cls_e;

  typedef struct packed {
    req_e           req;
    line_cls_e      cls;
    logic [LineCntW-1:0] len;
    logic [7:0]     tag;
    logic           reg_flag;
    logic [31:0]    timeout;
    logic [31:0]    now;
  } op_t;

  localparam int OpW = $bits(op_t);

  typedef struct packed {
    event_e              kind;
    logic [7:0]          tag;
    status_e             status;
    logic [LineCntW-1:0] llen;
    logic [RespCntW-1:0] rlen;
    logic                appended;
    logic                last;
  } result_t;

  localparam int ResW = $bits(result_t);

  function automatic logic [3:0] pat_len(input int p);
    case (p)
      0: pat_len = 4'd2;
      1: pat_len = 4'd5;
      2: pat_len = 4'd11;
      3: pat_len = 4'd11;
      4: pat_len = 4'd5;
      5: pat_len = 4'd6;
      6: pat_len = 4'd5;
      7: pat_len = 4'd7;
      8: pat_len = 4'd9;
      default: pat_len = 4'd6;
    endcase
  endfunction

  function automatic logic pat_exact(input int p);
    pat_exact = (p == 0) || (p == 1) || (p == 8);
  endfunction

  function automatic logic [7:0] pat_char(input int p, input logic [3:0] i);
    logic [87:0] s;
    case (p)
      0: s = {"OK", 72'd0};
      1: s = {"ERROR", 48'd0};
      2: s = "+CME ERROR:";
      3: s = "+CMS ERROR:";
      4: s = {"+CMT:", 48'd0};
      5: s = {"+CMTI:", 40'd0};
      6: s = {"+CDS:", 48'd0};
      7: s = {"+CEREG:", 32'd0};
      8: s = {"+MATREADY", 16'd0};
      default: s = {"+CPIN:", 40'd0};
    endcase
    pat_char = (i < 4'd11) ? s[8*(10 - 32'(i)) +: 8] : 8'd0;
  endfunction

endpackage

/* src/atcrt_front.sv */
module atcrt_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic                stall_i,
  input  logic [1:0]          req_type_i,
  input  logic [7:0]          rx_byte_i,
  input  logic [7:0]          cmd_tag_i,
  input  logic                cmd_is_reg_query_i,
  input  logic [31:0]         timeout_ms_i,
  input  logic [31:0]         now_ms_i,
  output logic                op_valid_o,
  output atcrt_pkg::op_t      op_o
);
  import atcrt_pkg::*;

  logic [LineCntW-1:0] line_count_q, line_count_d;
  logic                line_overflow_q, line_overflow_d;
  logic                awaiting_pdu_q, awaiting_pdu_d;
  logic [15:0]         prefix_q, prefix_d;
  logic                fire;
  logic [NumPat-1:0]   hit;
  line_cls_e           cls;

  assign fire = valid_i && !stall_i;

  always_comb begin
    for (int p = 0; p < NumPat; p++) begin
      if (pat_exact(p)) begin
        hit[p] = prefix_q[p] && (32'(line_count_q) == 32'(pat_len(p)));
      end else begin
        hit[p] = prefix_q[p] && (32'(line_count_q) >= 32'(pat_len(p)));
      end
    end
  end

  always_comb begin
    if (awaiting_pdu_q) begin
      cls = CL_PDU;
    end else if (hit[0]) begin
      cls = CL_OK;
    end else if (hit[1] || hit[2] || hit[3]) begin
      cls = CL_ERROR;
    end else if (hit[7]) begin
      cls = CL_CEREG;
    end else if (hit[4] || hit[5] || hit[6] || hit[8] || hit[9]) begin
      cls = CL_URC;
    end else begin
      cls = CL_OTHER;
    end
  end

  always_comb begin
    line_count_d    = line_count_q;
    line_overflow_d = line_overflow_q;
    awaiting_pdu_d  = awaiting_pdu_q;
    prefix_d        = prefix_q;
    op_valid_o      = 1'b0;
    op_o.req        = req_e'(req_type_i);
    op_o.cls        = CL_NONE;
    op_o.len        = line_count_q;
    op_o.tag        = cmd_tag_i;
    op_o.reg_flag   = cmd_is_reg_query_i;
    op_o.timeout    = timeout_ms_i;
    op_o.now        = now_ms_i;
    if (fire) begin
      case (req_e'(req_type_i))
        REQ_SUBMIT, REQ_TICK: op_valid_o = 1'b1;
        REQ_BYTE: begin
          if (rx_byte_i == 8'h0A) begin
            if (line_overflow_q) begin
              line_overflow_d = 1'b0;
            end else if (line_count_q != '0) begin
              op_valid_o = 1'b1;
              op_o.cls   = cls;
              // A +CMT: header makes the next line unsolicited; the PDU
              // line itself clears the mark.
              if (awaiting_pdu_q) begin
                awaiting_pdu_d = 1'b0;
              end else if (cls == CL_URC && hit[4]) begin
                awaiting_pdu_d = 1'b1;
              end
            end
            line_count_d = '0;
            prefix_d     = '1;
          end else if (rx_byte_i != 8'h0D) begin
            if (32'(line_count_q) + 32'd1 < 32'(LineCapacity)) begin
              for (int p = 0; p < NumPat; p++) begin
                if (32'(line_count_q) < 32'(pat_len(p))) begin
                  if (pat_char(p, line_count_q[3:0]) != rx_byte_i) begin
                    prefix_d[p] = 1'b0;
                  end
                end else if (pat_exact(p)) begin
                  prefix_d[p] = 1'b0;
                end
              end
              line_count_d = line_count_q + 1'b1;
            end else begin
              line_count_d    = '0;
              prefix_d        = '1;
              line_overflow_d = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_count_q    <= '0;
      line_overflow_q <= 1'b0;
      awaiting_pdu_q  <= 1'b0;
      prefix_q        <= '1;
    end else begin
      line_count_q    <= line_count_d;
      line_overflow_q <= line_overflow_d;
      awaiting_pdu_q  <= awaiting_pdu_d;
      prefix_q        <= prefix_d;
    end
  end

endmodule

/* src/atcrt_fifo.sv */
module atcrt_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  atcrt_pkg::op_t        data_i,
  input  logic                  pop_i,
  output logic                  valid_o,
  output atcrt_pkg::op_t        data_o,
  output logic [1:0]            count_o
);
  import atcrt_pkg::*;

  op_t        mem_q [FifoDepth];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

/* src/atcrt_back.sv */
module atcrt_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  op_valid_i,
  input  atcrt_pkg::op_t        op_i,
  output logic                  op_pop_o,
  output logic                  valid_o,
  input  logic                  stall_i,
  output atcrt_pkg::result_t    res_o
);
  import atcrt_pkg::*;

  logic [7:0]           q_tags [QueueDepth];
  logic [31:0]          q_tmo  [QueueDepth];
  logic                 q_reg  [QueueDepth];
  logic [QueueIdxW-1:0] head_q, head_d;
  logic [QueueCntW-1:0] count_q, count_d;
  logic                 busy_q, busy_d;
  logic [7:0]           tag_q, tag_d;
  logic                 reg_q, reg_d;
  logic [31:0]          deadline_q, deadline_d;
  logic [RespCntW-1:0]  resp_q, resp_d;

  // Two-slot result buffer; slot 1 holds the second result of an item.
  result_t r0_q, r1_q, r0_d, r1_d;
  logic    v0_q, v1_q;
  logic    n_res;
  logic    two;
  logic    free;
  logic    wr_en;
  logic [QueueIdxW-1:0] wr_idx;
  logic [31:0] diff;
  logic [RespCntW+1:0] need;
  logic [RespCntW-1:0] resp_app;
  logic    app_ok;

  assign valid_o = v0_q;
  assign res_o   = r0_q;
  // Accept a new op when the buffer will be empty after this cycle.
  assign free     = !v1_q && (!v0_q || !stall_i);
  assign op_pop_o = op_valid_i && free;

  function automatic result_t mk(event_e k, logic [7:0] t, status_e s,
                                 logic [LineCntW-1:0] l, logic [RespCntW-1:0] r,
                                 logic a);
    result_t x;
    x.kind = k; x.tag = t; x.status = s; x.llen = l; x.rlen = r;
    x.appended = a; x.last = 1'b0;
    return x;
  endfunction

  always_comb begin
    wr_idx = QueueIdxW'((32'(head_q) + 32'(count_q)) % QueueDepth);
  end

  assign diff     = op_i.now - deadline_q;
  assign need     = (RespCntW+2)'(resp_q) + (RespCntW+2)'(op_i.len) + (RespCntW+2)'(2);
  assign app_ok   = need < (RespCntW+2)'(ResponseCapacity);
  assign resp_app = resp_q + RespCntW'(op_i.len) + 1'b1;

  always_comb begin
    head_d = head_q; count_d = count_q; busy_d = busy_q; tag_d = tag_q;
    reg_d = reg_q; deadline_d = deadline_q; resp_d = resp_q;
    r0_d = mk(EV_ACCEPTED, 8'd0, ST_OK, '0, '0, 1'b0);
    r1_d = r0_d;
    n_res = 1'b0; two = 1'b0; wr_en = 1'b0;
    if (op_pop_o) begin
      case (op_i.req)
        REQ_SUBMIT: begin
          n_res = 1'b1;
          if (32'(count_q) >= QueueDepth) begin
            r0_d = mk(EV_REJECTED, op_i.tag, ST_OK, '0, '0, 1'b0);
          end else begin
            wr_en   = 1'b1;
            count_d = count_q + 1'b1;
            r0_d = mk(EV_ACCEPTED, op_i.tag, ST_OK, '0, '0, 1'b0);
          end
        end
        REQ_TICK: begin
          logic fin;
          fin = busy_q && !diff[31];
          if (fin) begin
            n_res = 1'b1;
            r0_d = mk(EV_DONE, tag_q, ST_TIMEOUT, '0, resp_q, 1'b0);
          end
          if ((fin || !busy_q) && count_q != '0) begin
            tag_d      = q_tags[head_q];
            reg_d      = q_reg[head_q];
            deadline_d = op_i.now + q_tmo[head_q];
            head_d     = QueueIdxW'((32'(head_q) + 1) % QueueDepth);
            count_d    = count_q - 1'b1;
            busy_d     = 1'b1;
            resp_d     = '0;
            if (fin) begin
              two  = 1'b1;
              r1_d = mk(EV_START, q_tags[head_q], ST_OK, '0, '0, 1'b0);
            end else begin
              n_res = 1'b1;
              r0_d = mk(EV_START, q_tags[head_q], ST_OK, '0, '0, 1'b0);
            end
          end else if (fin) begin
            busy_d = 1'b0;
          end
        end
        REQ_BYTE: begin
          n_res = 1'b1;
          case (op_i.cls)
            CL_OK: begin
              if (busy_q) begin
                busy_d = 1'b0;
                r0_d = mk(EV_DONE, tag_q, ST_OK, '0, resp_q, 1'b0);
              end else begin
                r0_d = mk(EV_URC, 8'd0, ST_OK, op_i.len, '0, 1'b0);
              end
            end
            CL_ERROR: begin
              if (busy_q) begin
                busy_d = 1'b0;
                two    = 1'b1;
                if (app_ok) resp_d = resp_app;
                r0_d = mk(EV_RESPONSE, tag_q, ST_OK, op_i.len,
                          app_ok ? resp_app : resp_q, app_ok);
                r1_d = mk(EV_DONE, tag_q, ST_ERROR, '0,
                          app_ok ? resp_app : resp_q, 1'b0);
              end else begin
                r0_d = mk(EV_URC, 8'd0, ST_OK, op_i.len, '0, 1'b0);
              end
            end
            CL_CEREG, CL_OTHER: begin
              if (busy_q && (op_i.cls == CL_OTHER || reg_q)) begin
                if (app_ok) resp_d = resp_app;
                r0_d = mk(EV_RESPONSE, tag_q, ST_OK, op_i.len,
                          app_ok ? resp_app : resp_q, app_ok);
              end else begin
                r0_d = mk(EV_URC, 8'd0, ST_OK, op_i.len, '0, 1'b0);
              end
            end
            default: r0_d = mk(EV_URC, 8'd0, ST_OK, op_i.len, '0, 1'b0);
          endcase
        end
        default: ;
      endcase
    end
    if (two) begin
      r1_d.last = 1'b1;
    end else begin
      r0_d.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      q_tags[wr_idx] <= op_i.tag;
      q_tmo[wr_idx]  <= op_i.timeout;
      q_reg[wr_idx]  <= op_i.reg_flag;
    end
    if (op_pop_o) begin
      r0_q <= r0_d;
      r1_q <= r1_d;
    end else if (v0_q && !stall_i) begin
      r0_q <= r1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0; count_q <= '0; busy_q <= 1'b0; tag_q <= '0;
      reg_q <= 1'b0; deadline_q <= '0; resp_q <= '0;
      v0_q <= 1'b0; v1_q <= 1'b0;
    end else begin
      head_q <= head_d; count_q <= count_d; busy_q <= busy_d; tag_q <= tag_d;
      reg_q <= reg_d; deadline_q <= deadline_d; resp_q <= resp_d;
      if (op_pop_o) begin
        v0_q <= n_res || two;
        v1_q <= n_res && two;
      end else if (v0_q && !stall_i) begin
        v0_q <= v1_q;
        v1_q <= 1'b0;
      end
    end
  end

endmodule

/* src/at_command_response_tracker.sv */
// AT command tracker.
// Input channel: valid_i / stall_o with req_type_i selecting a received byte,
// a command submit or a time tick. Output channel: valid_o / stall_i, one
// beat per result; last_o marks the final beat of an input item.
// An item is taken every cycle while the queue between the front and the
// back is empty or drains its entry. A byte updates the line state in the
// cycle it is taken; an LF that ends a line passes the line class, found in
// that cycle, through the queue and a result register before its result
// appears. A busy error line and a tick that both times out and starts a
// command give two beats, which the back end delivers one after the other.
// When the receiver stalls, results hold in a two-entry buffer, the queue
// fills, and stall_o rises once it is full or its entry does not drain.
// Reset empties the command queue and the queue between the parts, clears
// the line state and leaves no command running.
module at_command_response_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  cmd_tag_i,
  input  logic        cmd_is_reg_query_i,
  input  logic [31:0] timeout_ms_i,
  input  logic [31:0] now_ms_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [2:0]  event_kind_o,
  output logic [7:0]  event_tag_o,
  output logic [1:0]  done_status_o,
  output logic [8:0]  line_length_o,
  output logic [9:0]  response_length_o,
  output logic        appended_o,
  output logic        last_o
);
  import atcrt_pkg::*;

  logic    push, pop, fvalid;
  op_t     op_in, op_out;
  logic [1:0] fcnt;
  result_t res;

  // Conservative stall while the queue is full or its entry does not drain now.
  assign stall_o = (fcnt == 2'd2) || ((fcnt == 2'd1) && !pop);

  atcrt_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_i(stall_o), .req_type_i, .rx_byte_i,
    .cmd_tag_i, .cmd_is_reg_query_i, .timeout_ms_i, .now_ms_i,
    .op_valid_o(push), .op_o(op_in)
  );

  atcrt_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(op_in), .pop_i(pop),
    .valid_o(fvalid), .data_o(op_out), .count_o(fcnt)
  );

  atcrt_back u_back (
    .clk_i, .rst_ni, .op_valid_i(fvalid), .op_i(op_out), .op_pop_o(pop),
    .valid_o, .stall_i, .res_o(res)
  );

  assign event_kind_o      = res.kind;
  assign event_tag_o       = res.tag;
  assign done_status_o     = res.status;
  assign line_length_o     = res.llen;
  assign response_length_o = res.rlen;
  assign appended_o        = res.appended;
  assign last_o            = res.last;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fcnt == 2'd2 && push && !pop)) else $error("queue overflow");
  a_last_only_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |-> event_kind_o == EV_RESPONSE ||
      event_kind_o == EV_DONE) else $error("bad first beat");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o) else $error("result dropped");

endmodule

/* tb/tb_at_command_response_tracker.sv */
`timescale 1ns / 1ps

module tb_at_command_response_tracker;
  import atcrt_pkg::*;

  typedef struct {
    req_e        req;
    logic [7:0]  rx;
    logic [7:0]  tag;
    logic        reg_q;
    logic [31:0] tmo;
    logic [31:0] now;
    bit          hold;
  } beat_t;

  typedef struct {
    event_e      kind;
    logic [7:0]  tag;
    status_e     status;
    logic [8:0]  llen;
    logic [9:0]  rlen;
    logic        app;
    logic        last;
  } event_t;

  localparam int Depth   = 8;
  localparam int LineCap = 512;
  localparam int RespCap = 1024;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [1:0]  req_type_i = 2'd0;
  logic [7:0]  rx_byte_i = 8'd0;
  logic [7:0]  cmd_tag_i = 8'd0;
  logic        cmd_is_reg_query_i = 1'b0;
  logic [31:0] timeout_ms_i = 32'd0;
  logic [31:0] now_ms_i = 32'd0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic [2:0]  event_kind_o;
  logic [7:0]  event_tag_o;
  logic [1:0]  done_status_o;
  logic [8:0]  line_length_o;
  logic [9:0]  response_length_o;
  logic        appended_o;
  logic        last_o;

  at_command_response_tracker uut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Tracker state as the predictor sees it.
  string       prefixes [10] = '{"OK", "ERROR", "+CME ERROR:", "+CMS ERROR:", "+CMT:",
                                 "+CMTI:", "+CDS:", "+CEREG:", "+MATREADY", "+CPIN:"};
  bit          exact [10] = '{1, 1, 0, 0, 0, 0, 0, 0, 1, 0};
  logic [7:0]  ring_tag [Depth];
  logic [31:0] ring_tmo [Depth];
  logic        ring_reg [Depth];
  int          ring_head, ring_cnt;
  bit          running, run_reg, pdu_next, overlong;
  logic [7:0]  run_tag;
  logic [31:0] deadline;
  int          line_len, resp_len;
  logic [15:0] match;

  beat_t       pending [$];
  event_t      expected_events [$];
  int          errors = 0;
  int          cyc = 0;
  logic [31:0] now_cur = 32'd1000;

  function automatic void add_event(event_e k, logic [7:0] t, status_e s, int ll, int rl,
                                    logic a);
    event_t e;
    e.kind = k; e.tag = t; e.status = s; e.llen = ll[8:0]; e.rlen = rl[9:0];
    e.app = a; e.last = 1'b0;
    expected_events.push_back(e);
  endfunction

  function automatic bit matched(int p);
    if (!match[p]) return 0;
    return exact[p] ? (line_len == prefixes[p].len()) : (line_len >= prefixes[p].len());
  endfunction

  function automatic void close_cmd(status_e s);
    running = 0;
    add_event(EV_DONE, run_tag, s, 0, resp_len, 1'b0);
  endfunction

  function automatic void add_to_response();
    logic a;
    a = 1'b0;
    if (resp_len + line_len + 2 < RespCap) begin
      resp_len += line_len + 1;
      a = 1'b1;
    end
    add_event(EV_RESPONSE, run_tag, ST_OK, line_len, resp_len, a);
  endfunction

  function automatic void sort_line();
    bit urc;
    if (pdu_next) begin
      pdu_next = 0;
      add_event(EV_URC, 8'd0, ST_OK, line_len, 0, 1'b0);
    end else if (matched(0)) begin
      if (running) close_cmd(ST_OK);
      else add_event(EV_URC, 8'd0, ST_OK, line_len, 0, 1'b0);
    end else if (matched(1) || matched(2) || matched(3)) begin
      if (running) begin
        add_to_response();
        close_cmd(ST_ERROR);
      end else add_event(EV_URC, 8'd0, ST_OK, line_len, 0, 1'b0);
    end else begin
      urc = matched(4) || matched(5) || matched(6) || matched(7) || matched(8) || matched(9);
      if (urc && !(running && run_reg && matched(7))) begin
        if (matched(4)) pdu_next = 1;
        add_event(EV_URC, 8'd0, ST_OK, line_len, 0, 1'b0);
      end else if (running) add_to_response();
      else add_event(EV_URC, 8'd0, ST_OK, line_len, 0, 1'b0);
    end
  endfunction

  function automatic void track_beat(beat_t b);
    int first;
    int slot;
    logic [31:0] gap;
    first = expected_events.size();
    case (b.req)
      REQ_BYTE: begin
        if (b.rx == 8'h0A) begin
          if (overlong) overlong = 0;
          else if (line_len > 0) sort_line();
          line_len = 0; match = 16'hFFFF;
        end else if (b.rx != 8'h0D) begin
          if (line_len + 1 < LineCap) begin
            for (int p = 0; p < 10; p++) begin
              if (line_len < prefixes[p].len()) begin
                if (prefixes[p][line_len] != b.rx) match[p] = 1'b0;
              end else if (exact[p]) match[p] = 1'b0;
            end
            line_len++;
          end else begin
            line_len = 0; match = 16'hFFFF; overlong = 1;
          end
        end
      end
      REQ_SUBMIT: begin
        if (ring_cnt >= Depth) add_event(EV_REJECTED, b.tag, ST_OK, 0, 0, 1'b0);
        else begin
          slot = (ring_head + ring_cnt) % Depth;
          ring_tag[slot] = b.tag; ring_tmo[slot] = b.tmo; ring_reg[slot] = b.reg_q;
          ring_cnt++;
          add_event(EV_ACCEPTED, b.tag, ST_OK, 0, 0, 1'b0);
        end
      end
      REQ_TICK: begin
        gap = b.now - deadline;
        if (running && !gap[31]) close_cmd(ST_TIMEOUT);
        if (!running && ring_cnt > 0) begin
          run_tag = ring_tag[ring_head];
          run_reg = ring_reg[ring_head];
          deadline = b.now + ring_tmo[ring_head];
          ring_head = (ring_head + 1) % Depth;
          ring_cnt--;
          running = 1; resp_len = 0;
          add_event(EV_START, run_tag, ST_OK, 0, 0, 1'b0);
        end
      end
      default: ;
    endcase
    if (expected_events.size() > first)
      expected_events[expected_events.size() - 1].last = 1'b1;
  endfunction

  // Driver: a beat stays on the port until it is taken.
  always @(posedge clk_i) begin
    beat_t b;
    bit    taken;
    cyc <= cyc + 1;
    taken = valid_i && !stall_o;
    if (taken) begin
      b.req = req_e'(req_type_i); b.rx = rx_byte_i; b.tag = cmd_tag_i;
      b.reg_q = cmd_is_reg_query_i; b.tmo = timeout_ms_i; b.now = now_ms_i; b.hold = 0;
      track_beat(b);
    end
    if (rst_ni && (!valid_i || taken)) begin
      if (pending.size() > 0 && pending[0].hold) begin
        valid_i <= 1'b0;
        if (expected_events.size() == 0) void'(pending.pop_front());
      end else if (pending.size() > 0 &&
                   ((cyc > 600 && cyc < 1400) || $urandom_range(0, 99) >= 20)) begin
        b = pending.pop_front();
        valid_i <= 1'b1;
        req_type_i <= b.req; rx_byte_i <= b.rx; cmd_tag_i <= b.tag;
        cmd_is_reg_query_i <= b.reg_q; timeout_ms_i <= b.tmo; now_ms_i <= b.now;
      end else valid_i <= 1'b0;
    end
  end

  // Monitor: checks each taken result beat against the oldest prediction.
  always @(posedge clk_i) begin
    event_t e;
    if (valid_o && !stall_i) begin
      if (expected_events.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result kind=%0d tag=%0d", event_kind_o,
                                   event_tag_o);
      end else begin
        e = expected_events.pop_front();
        if (event_kind_o !== e.kind || event_tag_o !== e.tag ||
            done_status_o !== e.status || line_length_o !== e.llen ||
            response_length_o !== e.rlen || appended_o !== e.app || last_o !== e.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp k%0d t%0d s%0d l%0d r%0d a%0d z%0d got k%0d t%0d s%0d l%0d r%0d a%0d z%0d",
                     e.kind, e.tag, e.status, e.llen, e.rlen, e.app, e.last,
                     event_kind_o, event_tag_o, done_status_o, line_length_o,
                     response_length_o, appended_o, last_o);
        end
      end
    end
    stall_i <= (cyc > 600 && cyc < 1400) ? 1'b0 : ($urandom_range(0, 99) < 20);
  end

  function automatic beat_t blank();
    beat_t b;
    b.req = REQ_BYTE; b.rx = 8'd0; b.tag = 8'd0; b.reg_q = 1'b0;
    b.tmo = 32'd0; b.now = 32'd0; b.hold = 0;
    return b;
  endfunction

  function automatic void send_byte(logic [7:0] c);
    beat_t b;
    b = blank(); b.rx = c;
    pending.push_back(b);
  endfunction

  function automatic void send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endfunction

  function automatic void send_noise(int n);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(0, 255);
      if (c == 8'h0A) c = 8'h0B;
      send_byte(c);
    end
  endfunction

  function automatic void end_line();
    if ($urandom_range(0, 1)) send_byte(8'h0D);
    send_byte(8'h0A);
  endfunction

  function automatic void submit(logic [7:0] t, logic r, logic [31:0] to);
    beat_t b;
    b = blank(); b.req = REQ_SUBMIT; b.tag = t; b.reg_q = r; b.tmo = to;
    pending.push_back(b);
  endfunction

  function automatic void tick(logic [31:0] n);
    beat_t b;
    b = blank(); b.req = REQ_TICK; b.now = n;
    pending.push_back(b);
  endfunction

  function automatic void wait_drain();
    beat_t b;
    b = blank(); b.hold = 1;
    pending.push_back(b);
  endfunction

  initial begin
    beat_t b;
    int    pick;
    running = 0; run_reg = 0; pdu_next = 0; overlong = 0; run_tag = 8'd0;
    deadline = 32'd0; line_len = 0; resp_len = 0; match = 16'hFFFF;
    ring_head = 0; ring_cnt = 0;

    // Directed: idle tick, unused request code, full queue, finish, a start with
    // zero timeout, an empty line and a line holding only a NUL byte.
    tick(32'hFFFF_FFFF);
    b = blank(); b.req = REQ_NONE; b.rx = 8'hFF; pending.push_back(b);
    submit(8'd0, 1'b0, 32'hFFFF_FFFF);
    submit(8'd255, 1'b1, 32'd0);
    for (int i = 0; i < 7; i++) submit(8'(i + 1), 1'b0, 32'd100);
    tick(32'd0);
    send_text("OK"); end_line();
    tick(32'h8000_0000);
    send_byte(8'h0A);
    send_byte(8'h00); send_byte(8'h0A);
    wait_drain();

    while (pending.size() < 1650) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) submit($urandom, $urandom_range(0, 1),
                            $urandom_range(0, 9) == 0 ? ($urandom & 32'h3FFF_FFFF)
                                                      : $urandom_range(500, 5000));
      else if (pick < 25) begin
        if ($urandom_range(0, 19) == 0) now_cur = $urandom;
        else now_cur += $urandom_range(0, 2000);
        tick(now_cur);
      end else if (pick < 90) begin
        case ($urandom_range(0, 13))
          0, 1: send_text("OK");
          2: send_text("ERROR");
          3: begin send_text("+CME ERROR: "); send_noise($urandom_range(0, 3)); end
          4: begin send_text("+CMS ERROR:"); send_noise($urandom_range(0, 3)); end
          5: send_text("+CMT: \"x\",,20");
          6: send_text("+CMTI: \"SM\",3");
          7: send_text("+CDS: 1");
          8: send_text("+CEREG: 1,5");
          9: send_text("+MATREADY");
          10: send_text("+CPIN: READY");
          11: send_text("OKAY");
          12: send_text("+CM");
          default: send_noise($urandom_range(0, 4) == 0 ? $urandom_range(40, 200)
                                                          : $urandom_range(1, 12));
        endcase
        end_line();
      end else if (pick < 96) send_noise(1);
      else if (pick < 98) begin
        b = blank(); b.req = REQ_NONE; b.rx = $urandom; pending.push_back(b);
      end else if (pick == 98 && $urandom_range(0, 3) == 0) begin
        send_noise($urandom_range(511, 530)); send_byte(8'h0A);
      end else begin
        // Drain the queue by timeouts, then fill one long response past capacity.
        for (int i = 0; i < 10; i++) begin
          now_cur += 32'h4000_0000;
          tick(now_cur);
        end
        submit($urandom, 1'b0, 32'h3000_0000);
        tick(now_cur);
        for (int i = 0; i < 11; i++) begin
          send_byte(8'h78); send_noise(99); end_line();
        end
        send_text("ERROR"); end_line();
        wait_drain();
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending.size() == 0);
    @(posedge clk_i);
    while (valid_i) @(posedge clk_i);
    while (expected_events.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && expected_events.size() == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #12_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
